// ===== src/argm_pkg.sv =====
// argm_pkg: shared constants and types for the streaming argmax block.
// No dependencies; imported by every module under src.
package argm_pkg;

  localparam int DEF_DATA_WIDTH = 16;
  localparam int DEF_MAX_INNER  = 1024;
  localparam int DEF_MAX_AXIS   = 4096;

  // configuration port
  localparam int CFG_W         = 17;
  localparam int CFG_IDX_W     = 2;
  localparam int AXIS_FIELD_W  = 13;
  localparam int INNER_FIELD_W = 11;
  localparam int OUTER_FIELD_W = 17;
  localparam int OUTER_LIMIT   = 65536;
  localparam int OUTER_POS_W   = 16;

  // result queue depth
  localparam int FIFO_DEPTH = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_AXIS_LENGTH = 2'd0,
    REG_INNER_SIZE  = 2'd1,
    REG_OUTER_SIZE  = 2'd2
  } cfg_reg_t;

  // per-beat control travelling with an element into the column store
  typedef struct packed {
    logic first;  // axis position zero: overwrite column entry
    logic emit;   // last axis position: produce a result
    logic last;   // final result of the tensor
  } item_ctl_t;

endpackage

// ===== src/argm_col_store.sv =====
// argm_col_store: per-column best value/index memory with read-modify-write.
// Depends on argm_pkg (item_ctl_t).
module argm_col_store import argm_pkg::*; #(
  parameter int DATA_WIDTH = DEF_DATA_WIDTH,
  parameter int MAX_INNER  = DEF_MAX_INNER,
  parameter int MAX_AXIS   = DEF_MAX_AXIS
) (
  input  logic                                       clk,
  input  logic                                       rst_n,
  input  logic                                       acc,
  input  logic [((MAX_INNER > 1) ? $clog2(MAX_INNER) : 1)-1:0] col,
  input  logic [$clog2(MAX_AXIS)-1:0]                axis_pos,
  input  logic [DATA_WIDTH-1:0]                      value,
  input  item_ctl_t                                  ctl,
  output logic                                       res_valid,
  output logic [$clog2(MAX_AXIS)-1:0]                res_index,
  output logic                                       res_last,
  output logic                                       emit_pending
);

  localparam int COL_W  = (MAX_INNER > 1) ? $clog2(MAX_INNER) : 1;
  localparam int AX_W   = $clog2(MAX_AXIS);
  localparam int WORD_W = DATA_WIDTH + AX_W;

  logic [WORD_W-1:0] mem [MAX_INNER];
  logic [WORD_W-1:0] rd_q_r;

  logic              s1_valid_r;
  logic [COL_W-1:0]  s1_col_r;
  logic [AX_W-1:0]   s1_pos_r;
  logic [DATA_WIDTH-1:0] s1_val_r;
  item_ctl_t         s1_ctl_r;

  logic              fwd_valid_r;
  logic [COL_W-1:0]  fwd_col_r;
  logic [WORD_W-1:0] fwd_word_r;

  logic [WORD_W-1:0]     old_word;
  logic [DATA_WIDTH-1:0] old_val;
  logic [AX_W-1:0]       old_idx;
  logic                  take;
  logic [AX_W-1:0]       new_idx;
  logic [WORD_W-1:0]     wr_word;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      fwd_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= acc;
      fwd_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_col_r <= col;
      s1_pos_r <= axis_pos;
      s1_val_r <= value;
      s1_ctl_r <= ctl;
    end
    fwd_col_r  <= s1_col_r;
    fwd_word_r <= wr_word;
  end

  // memory: read at acceptance, write back on the next edge
  always_ff @(posedge clk) begin
    if (acc) begin
      rd_q_r <= mem[col];
    end
    if (s1_valid_r) begin
      mem[s1_col_r] <= wr_word;
    end
  end

  // write-back of the previous beat lands on the same edge as our read
  always_comb begin
    if (fwd_valid_r && (fwd_col_r == s1_col_r)) begin
      old_word = fwd_word_r;
    end else begin
      old_word = rd_q_r;
    end
    old_val = old_word[WORD_W-1:AX_W];
    old_idx = old_word[AX_W-1:0];
    take    = s1_ctl_r.first || ($signed(s1_val_r) > $signed(old_val));
    new_idx = take ? s1_pos_r : old_idx;
    wr_word = take ? {s1_val_r, s1_pos_r} : old_word;
  end

  assign res_valid    = s1_valid_r && s1_ctl_r.emit;
  assign res_index    = new_idx;
  assign res_last     = s1_ctl_r.last;
  assign emit_pending = res_valid;

endmodule

// ===== src/argm_out_fifo.sv =====
// argm_out_fifo: small result queue between the column store and the output.
// Depends on argm_pkg (FIFO_DEPTH).
module argm_out_fifo import argm_pkg::*; #(
  parameter int W = 13
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              push,
  input  logic [W-1:0]                      push_data,
  input  logic                              pop,
  output logic                              out_valid,
  output logic [W-1:0]                      out_data,
  output logic [$clog2(FIFO_DEPTH+1)-1:0]   count
);

  localparam int PTR_W = $clog2(FIFO_DEPTH);
  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

  logic [W-1:0]     ent_r [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (32'(wr_ptr_r) == FIFO_DEPTH - 1) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (32'(rd_ptr_r) == FIFO_DEPTH - 1) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= push_data;
    end
  end

  assign out_valid = (cnt_r != '0);
  assign out_data  = ent_r[rd_ptr_r];
  assign count     = cnt_r;

endmodule

// ===== src/axis_argmax_stream.sv =====
// axis_argmax_stream: streaming argmax along one axis of a tensor.
// Depends on argm_pkg, argm_col_store and argm_out_fifo.
//
// Takes one signed element per beat in memory order (inner index fastest,
// then axis, then outer) and emits, on the last axis element of each column,
// the axis index of that column's first maximum; out_last_result flags the
// final result of the tensor. Sustained rate is one element per clock when not
// stalled: the column store memory is read on the accepting edge, compared and
// written back on the next, and a one-entry forward register covers a
// back-to-back hit on the same column (inner_size of 1). A result is registered
// in the store and leaves through a three-beat output queue; in_stall rises
// only when that queue cannot take another pending result. Column entries need
// no clearing: each is overwritten at axis position zero before it is read. Any
// configuration write to a listed register returns the stream to the start of a
// tensor; registers written as zero act as one and values above range saturate.
module axis_argmax_stream import argm_pkg::*; #(
  parameter int DATA_WIDTH = DEF_DATA_WIDTH,
  parameter int MAX_INNER  = DEF_MAX_INNER,
  parameter int MAX_AXIS   = DEF_MAX_AXIS
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // element beats
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [DATA_WIDTH-1:0]       in_element_value,
  // result beats
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [$clog2(MAX_AXIS)-1:0] out_max_index,
  output logic                        out_last_result,
  // configuration writes
  input  logic                        cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [CFG_W-1:0]            cfg_data
);

  localparam int COL_W = (MAX_INNER > 1) ? $clog2(MAX_INNER) : 1;
  localparam int AX_W  = $clog2(MAX_AXIS);
  localparam int AL_W  = $clog2(MAX_AXIS + 1);
  localparam int IL_W  = $clog2(MAX_INNER + 1);
  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
  localparam int RES_W = AX_W + 1;

  // configuration registers (already clamped)
  logic [AL_W-1:0]          axis_len_r;
  logic [IL_W-1:0]          inner_len_r;
  logic [OUTER_FIELD_W-1:0] outer_len_r;

  // stream position
  logic [COL_W-1:0]       inner_pos_r;
  logic [AX_W-1:0]        axis_pos_r;
  logic [OUTER_POS_W-1:0] outer_pos_r;

  logic      acc;
  logic      cfg_hit;
  logic      inner_end, axis_end, outer_end;
  item_ctl_t ctl;
  int        axis_fld, inner_fld, outer_fld;
  int        axis_clamp, inner_clamp, outer_clamp;

  logic              res_valid;
  logic [AX_W-1:0]   res_index;
  logic              res_last;
  logic              emit_pending;
  logic [RES_W-1:0]  q_data;
  logic [CNT_W-1:0]  q_count;
  logic              pop;

  // --- configuration: mask to the field, zero acts as one, saturate
  always_comb begin
    axis_fld  = int'(cfg_data[AXIS_FIELD_W-1:0]);
    inner_fld = int'(cfg_data[INNER_FIELD_W-1:0]);
    outer_fld = int'(cfg_data[OUTER_FIELD_W-1:0]);
    axis_clamp  = (axis_fld == 0) ? 1 : ((axis_fld > MAX_AXIS) ? MAX_AXIS : axis_fld);
    inner_clamp = (inner_fld == 0) ? 1 :
                  ((inner_fld > MAX_INNER) ? MAX_INNER : inner_fld);
    outer_clamp = (outer_fld == 0) ? 1 :
                  ((outer_fld > OUTER_LIMIT) ? OUTER_LIMIT : outer_fld);
    case (cfg_index)
      REG_AXIS_LENGTH,
      REG_INNER_SIZE,
      REG_OUTER_SIZE: cfg_hit = cfg_wr_en;
      default:        cfg_hit = 1'b0;   // index beyond the list is ignored
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      axis_len_r  <= AL_W'(1);
      inner_len_r <= IL_W'(1);
      outer_len_r <= OUTER_FIELD_W'(1);
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_AXIS_LENGTH: axis_len_r  <= AL_W'(axis_clamp);
        REG_INNER_SIZE:  inner_len_r <= IL_W'(inner_clamp);
        REG_OUTER_SIZE:  outer_len_r <= OUTER_FIELD_W'(outer_clamp);
        default: ;
      endcase
    end
  end

  // --- position counters
  assign inner_end = (32'(inner_pos_r) + 32'd1) >= 32'(inner_len_r);
  assign axis_end  = (32'(axis_pos_r)  + 32'd1) >= 32'(axis_len_r);
  assign outer_end = (32'(outer_pos_r) + 32'd1) >= 32'(outer_len_r);

  always_comb begin
    ctl.first = (axis_pos_r == '0);
    ctl.emit  = axis_end;
    ctl.last  = outer_end && inner_end;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cfg_hit) begin
      inner_pos_r <= '0;
      axis_pos_r  <= '0;
      outer_pos_r <= '0;
    end else if (acc) begin
      if (inner_end) begin
        inner_pos_r <= '0;
        if (axis_end) begin
          axis_pos_r  <= '0;
          outer_pos_r <= outer_end ? '0 : outer_pos_r + 1'b1;
        end else begin
          axis_pos_r <= axis_pos_r + 1'b1;
        end
      end else begin
        inner_pos_r <= inner_pos_r + 1'b1;
      end
    end
  end

  // --- flow control: room for the beat in the store plus one more
  assign in_stall = (32'(q_count) + 32'(emit_pending)) >= FIFO_DEPTH;
  assign acc      = in_valid && !in_stall;

  argm_col_store #(
    .DATA_WIDTH (DATA_WIDTH),
    .MAX_INNER  (MAX_INNER),
    .MAX_AXIS   (MAX_AXIS)
  ) u_store (
    .clk          (clk),
    .rst_n        (rst_n),
    .acc          (acc),
    .col          (inner_pos_r),
    .axis_pos     (axis_pos_r),
    .value        (in_element_value),
    .ctl          (ctl),
    .res_valid    (res_valid),
    .res_index    (res_index),
    .res_last     (res_last),
    .emit_pending (emit_pending)
  );

  assign pop = out_valid && !out_stall;

  argm_out_fifo #(
    .W (RES_W)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_valid),
    .push_data ({res_index, res_last}),
    .pop       (pop),
    .out_valid (out_valid),
    .out_data  (q_data),
    .count     (q_count)
  );

  assign out_max_index   = q_data[RES_W-1:1];
  assign out_last_result = q_data[0];

endmodule
